// File: src/i2cmts_pkg.sv
// Shared types, status codes and constants for the I2C master transfer sequencer.
`timescale 1ns / 1ps

package i2cmts_pkg;

  // Longest transfer the byte counters are loaded with
  localparam int unsigned MAX_LEN = 256;
  localparam int unsigned CNT_W   = 9;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] LEN_LIMIT =
    CNT_W'((MAX_LEN > 511) ? 511 : MAX_LEN);

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SLAVE_ADDR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEND_LEN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECV_LEN   = 2'd2;
  localparam int unsigned CFG_DATA_W = 9;

  // Item kinds
  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_STATUS = 1'b1;

  // Controller status codes (low three bits masked off)
  localparam logic [7:0] STATUS_MASK       = 8'hF8;
  localparam logic [7:0] ST_START          = 8'h08;
  localparam logic [7:0] ST_RSTART         = 8'h10;
  localparam logic [7:0] ST_MT_SLA_ACK     = 8'h18;
  localparam logic [7:0] ST_MT_SLA_NACK    = 8'h20;
  localparam logic [7:0] ST_MT_DATA_ACK    = 8'h28;
  localparam logic [7:0] ST_MT_DATA_NACK   = 8'h30;
  localparam logic [7:0] ST_ARB_LOST       = 8'h38;
  localparam logic [7:0] ST_MR_SLA_ACK     = 8'h40;
  localparam logic [7:0] ST_MR_SLA_NACK    = 8'h48;
  localparam logic [7:0] ST_MR_DATA_ACK    = 8'h50;
  localparam logic [7:0] ST_MR_DATA_NACK   = 8'h58;

  typedef enum logic [1:0] {
    ACK_KEEP  = 2'd0,
    ACK_SET   = 2'd1,
    ACK_CLEAR = 2'd2
  } ack_e;

  typedef enum logic [1:0] {
    STA_KEEP  = 2'd0,
    STA_SET   = 2'd1,
    STA_CLEAR = 2'd2
  } sta_e;

  typedef struct packed {
    logic [6:0]       slave_address;
    logic [CNT_W-1:0] send_length;
    logic [CNT_W-1:0] recv_length;
  } cfg_t;

  typedef struct packed {
    logic       cmd;
    logic       read_not_write;
    logic [7:0] status_code;
    logic [7:0] bus_byte;
    logic [7:0] tx_byte;
  } item_t;

  typedef struct packed {
    logic             load_data;
    logic [7:0]       data_out;
    logic [7:0]       tx_index;
    logic             rx_valid;
    logic [7:0]       rx_data;
    logic [7:0]       rx_index;
    ack_e             ack_mode;
    logic             send_stop;
    sta_e             start_ctrl;
    logic             done_res;
    logic [CNT_W-1:0] bytes_moved;
  } res_t;

endpackage

// File: src/i2c_master_transfer_sequencer.sv
// An accepted input beat is held in the input register, then its result in the result register on the master side.
// Throughput: one item per cycle while m_tready_i is high; the input register refills while a result waits.
// The rate is set by the single decision stage between input and result registers.
// Reset clears the configuration registers, the transfer counters and both valid flags.
// Configuration writes are taken in every cycle (cfg_ready_o is always high).
`timescale 1ns / 1ps

module i2c_master_transfer_sequencer (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Configuration write channel
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [i2cmts_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [i2cmts_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // Input stream
  input  logic                                  s_tvalid_i,
  output logic                                  s_tready_o,
  // tdata: read_not_write[0], status_code[8:1], bus_byte[16:9], tx_byte[24:17], zero[31:25]
  input  logic [31:0]                           s_tdata_i,
  // tuser: cmd[0]
  input  logic                                  s_tuser_i,
  // Result stream
  output logic                                  m_tvalid_o,
  input  logic                                  m_tready_i,
  // tdata: data_out[7:0], tx_index[15:8], rx_data[23:16], rx_index[31:24],
  //        ack_mode[33:32], send_stop[34], start_ctrl[36:35], bytes_moved[45:37], zero[47:46]
  output logic [47:0]                           m_tdata_o,
  // tuser: load_data[0], rx_valid[1]
  output logic [1:0]                            m_tuser_o,
  // tlast: done_res
  output logic                                  m_tlast_o
);

  i2cmts_pkg::cfg_t  cfg;
  i2cmts_pkg::item_t in_item_q;
  i2cmts_pkg::res_t  res, out_res_q;
  logic              in_valid_q, out_valid_q;
  logic              advance, in_accept;

  assign cfg_ready_o = 1'b1;

  i2cmts_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Move the held item into the result register when that slot frees up
  assign advance    = in_valid_q && (!out_valid_q || m_tready_i);
  assign s_tready_o = !in_valid_q || advance;
  assign in_accept  = s_tvalid_i && s_tready_o;

  i2cmts_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .item_i (in_item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Input register valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_tready_o) begin
      in_valid_q <= s_tvalid_i;
    end
  end

  // Capture the input beat
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_item_q.cmd            <= s_tuser_i;
      in_item_q.read_not_write <= s_tdata_i[0];
      in_item_q.status_code    <= s_tdata_i[8:1];
      in_item_q.bus_byte       <= s_tdata_i[16:9];
      in_item_q.tx_byte        <= s_tdata_i[24:17];
    end
  end

  // Result register valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Hold the result beat
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {2'b00,
                       out_res_q.bytes_moved,
                       out_res_q.start_ctrl,
                       out_res_q.send_stop,
                       out_res_q.ack_mode,
                       out_res_q.rx_index,
                       out_res_q.rx_data,
                       out_res_q.tx_index,
                       out_res_q.data_out};
  assign m_tuser_o  = {out_res_q.rx_valid, out_res_q.load_data};
  assign m_tlast_o  = out_res_q.done_res;

endmodule

// File: src/i2cmts_cfg.sv
// Configuration registers: slave address and transfer lengths.
`timescale 1ns / 1ps

module i2cmts_cfg (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  wr_en_i,
  input  logic [i2cmts_pkg::CFG_IDX_W-1:0]      wr_index_i,
  input  logic [i2cmts_pkg::CFG_DATA_W-1:0]     wr_data_i,
  output i2cmts_pkg::cfg_t                      cfg_o
);

  i2cmts_pkg::cfg_t cfg_q, cfg_d;

  // Decode the register index; writes to unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_index_i)
        i2cmts_pkg::REG_SLAVE_ADDR: cfg_d.slave_address = wr_data_i[6:0];
        i2cmts_pkg::REG_SEND_LEN:   cfg_d.send_length   = wr_data_i;
        i2cmts_pkg::REG_RECV_LEN:   cfg_d.recv_length   = wr_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: src/i2cmts_step.sv
// Transfer state and the per-item decision logic of the sequencer.
`timescale 1ns / 1ps

module i2cmts_step (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  i2cmts_pkg::item_t  item_i,
  input  i2cmts_pkg::cfg_t   cfg_i,
  output i2cmts_pkg::res_t   res_o
);

  localparam int unsigned W = i2cmts_pkg::CNT_W;

  logic         read_mode_q, read_mode_d;
  logic [W-1:0] tx_rem_q, tx_rem_d;
  logic [W-1:0] rx_rem_q, rx_rem_d;
  logic [W-1:0] tx_pos_q, tx_pos_d;
  logic [W-1:0] rx_pos_q, rx_pos_d;

  logic [7:0]   code;
  logic [W-1:0] tx_pos_inc, rx_pos_inc, tx_rem_dec, rx_rem_dec;
  logic [W-1:0] send_len_clamped, recv_len_clamped;

  assign code = item_i.status_code & i2cmts_pkg::STATUS_MASK;

  // Saturating counter steps
  assign tx_pos_inc = (tx_pos_q == i2cmts_pkg::CNT_MAX) ? tx_pos_q : tx_pos_q + W'(1);
  assign rx_pos_inc = (rx_pos_q == i2cmts_pkg::CNT_MAX) ? rx_pos_q : rx_pos_q + W'(1);
  assign tx_rem_dec = (tx_rem_q == '0) ? tx_rem_q : tx_rem_q - W'(1);
  assign rx_rem_dec = (rx_rem_q == '0) ? rx_rem_q : rx_rem_q - W'(1);

  // Clamp the programmed lengths to the counter limit
  assign send_len_clamped = (cfg_i.send_length > i2cmts_pkg::LEN_LIMIT) ?
                            i2cmts_pkg::LEN_LIMIT : cfg_i.send_length;
  assign recv_len_clamped = (cfg_i.recv_length > i2cmts_pkg::LEN_LIMIT) ?
                            i2cmts_pkg::LEN_LIMIT : cfg_i.recv_length;

  // Decide the controller action and the next transfer state
  always_comb begin
    res_o       = '0;
    read_mode_d = read_mode_q;
    tx_rem_d    = tx_rem_q;
    rx_rem_d    = rx_rem_q;
    tx_pos_d    = tx_pos_q;
    rx_pos_d    = rx_pos_q;

    if (item_i.cmd == i2cmts_pkg::CMD_START) begin
      read_mode_d      = item_i.read_not_write;
      tx_rem_d         = send_len_clamped;
      rx_rem_d         = recv_len_clamped;
      tx_pos_d         = '0;
      rx_pos_d         = '0;
      res_o.ack_mode   = item_i.read_not_write ? i2cmts_pkg::ACK_KEEP
                                               : i2cmts_pkg::ACK_CLEAR;
      res_o.start_ctrl = i2cmts_pkg::STA_SET;
    end else begin
      case (code) inside
        i2cmts_pkg::ST_START, i2cmts_pkg::ST_RSTART: begin
          res_o.load_data  = 1'b1;
          res_o.data_out   = {cfg_i.slave_address, read_mode_q};
          res_o.start_ctrl = i2cmts_pkg::STA_CLEAR;
        end
        i2cmts_pkg::ST_MT_SLA_ACK, i2cmts_pkg::ST_MT_DATA_ACK: begin
          // Address ack always loads the first byte; data ack only while bytes remain
          if (code == i2cmts_pkg::ST_MT_SLA_ACK || tx_rem_q != '0) begin
            res_o.load_data = 1'b1;
            res_o.data_out  = item_i.tx_byte;
            res_o.tx_index  = tx_pos_q[7:0];
            tx_pos_d        = tx_pos_inc;
            tx_rem_d        = tx_rem_dec;
          end else begin
            res_o.send_stop = 1'b1;
            res_o.done_res  = 1'b1;
          end
          res_o.start_ctrl = i2cmts_pkg::STA_CLEAR;
        end
        i2cmts_pkg::ST_MT_SLA_NACK, i2cmts_pkg::ST_MT_DATA_NACK,
        i2cmts_pkg::ST_MR_SLA_NACK: begin
          res_o.send_stop  = 1'b1;
          res_o.start_ctrl = i2cmts_pkg::STA_CLEAR;
          res_o.done_res   = 1'b1;
        end
        i2cmts_pkg::ST_ARB_LOST: begin
          res_o.send_stop = 1'b1;
          res_o.done_res  = 1'b1;
        end
        i2cmts_pkg::ST_MR_SLA_ACK: begin
          res_o.ack_mode   = (rx_rem_q <= W'(1)) ? i2cmts_pkg::ACK_CLEAR
                                                 : i2cmts_pkg::ACK_SET;
          res_o.start_ctrl = i2cmts_pkg::STA_CLEAR;
        end
        i2cmts_pkg::ST_MR_DATA_ACK, i2cmts_pkg::ST_MR_DATA_NACK: begin
          res_o.rx_valid = 1'b1;
          res_o.rx_data  = item_i.bus_byte;
          res_o.rx_index = rx_pos_q[7:0];
          rx_pos_d       = rx_pos_inc;
          rx_rem_d       = rx_rem_dec;
          if (code == i2cmts_pkg::ST_MR_DATA_ACK) begin
            res_o.ack_mode = (rx_rem_dec <= W'(1)) ? i2cmts_pkg::ACK_CLEAR
                                                   : i2cmts_pkg::ACK_SET;
          end else begin
            res_o.send_stop = 1'b1;
            res_o.done_res  = 1'b1;
          end
          res_o.start_ctrl = i2cmts_pkg::STA_CLEAR;
        end
        default: begin
          // Unknown status: stop and restart
          res_o.send_stop  = 1'b1;
          res_o.start_ctrl = i2cmts_pkg::STA_SET;
        end
      endcase
    end

    res_o.bytes_moved = read_mode_d ? rx_pos_d : tx_pos_d;
  end

  // Advance the transfer state once per processed item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_mode_q <= 1'b0;
      tx_rem_q    <= '0;
      rx_rem_q    <= '0;
      tx_pos_q    <= '0;
      rx_pos_q    <= '0;
    end else if (en_i) begin
      read_mode_q <= read_mode_d;
      tx_rem_q    <= tx_rem_d;
      rx_rem_q    <= rx_rem_d;
      tx_pos_q    <= tx_pos_d;
      rx_pos_q    <= rx_pos_d;
    end
  end

endmodule

// File: bench/i2cmts_check.sv
// Checker for the I2C master transfer sequencer: predicts each result beat and compares it.
`timescale 1ns / 1ps

module i2cmts_check
  import i2cmts_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                 s_tvalid_i,
  input  logic                 s_tready_i,
  // tdata: read_not_write[0], status_code[8:1], bus_byte[16:9], tx_byte[24:17], zero[31:25]
  input  logic [31:0]          s_tdata_i,
  // tuser: cmd[0]
  input  logic                 s_tuser_i,
  input  logic                 m_tvalid_i,
  input  logic                 m_tready_i,
  // tdata: data_out[7:0], tx_index[15:8], rx_data[23:16], rx_index[31:24], ack_mode[33:32],
  //        send_stop[34], start_ctrl[36:35], bytes_moved[45:37], zero[47:46]
  input  logic [47:0]          m_tdata_i,
  // tuser: load_data[0], rx_valid[1]
  input  logic [1:0]           m_tuser_i,
  input  logic                 m_tlast_i,
  output int                   mismatches_o,
  output int                   open_results_o,
  output int                   results_seen_o
);

  localparam logic [CNT_W-1:0] LEN_CAP = CNT_W'((MAX_LEN > 511) ? 511 : MAX_LEN);

  // Register copies
  logic [6:0]       slave_addr = '0;
  logic [CNT_W-1:0] len_send   = '0;
  logic [CNT_W-1:0] len_recv   = '0;

  // Transfer state
  logic             rd_mode = 1'b0;
  logic [CNT_W-1:0] tx_left = '0;
  logic [CNT_W-1:0] rx_left = '0;
  logic [CNT_W-1:0] tx_pos  = '0;
  logic [CNT_W-1:0] rx_pos  = '0;

  res_t pending_actions[$];

  initial begin
    mismatches_o   = 0;
    open_results_o = 0;
    results_seen_o = 0;
  end

  function automatic logic [CNT_W-1:0] clamp_len(input logic [CNT_W-1:0] v);
    return (v > LEN_CAP) ? LEN_CAP : v;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [CNT_W-1:0] sat_dec(input logic [CNT_W-1:0] v);
    return (v == '0) ? v : v - 1'b1;
  endfunction

  // Work out what the controller is told to do next, and advance the transfer state
  function automatic res_t next_action(input logic cmd, input logic rnw,
                                       input logic [7:0] raw_code,
                                       input logic [7:0] bus_byte, input logic [7:0] tx_byte);
    res_t       r;
    logic [7:0] code;
    r = '0;
    if (cmd == CMD_START) begin
      rd_mode = rnw;
      tx_left = clamp_len(len_send);
      rx_left = clamp_len(len_recv);
      tx_pos = '0;
      rx_pos = '0;
      r.ack_mode = rnw ? ACK_KEEP : ACK_CLEAR;
      r.start_ctrl = STA_SET;
    end else begin
      code = raw_code & STATUS_MASK;
      case (code)
        ST_START, ST_RSTART: begin
          r.load_data = 1'b1;
          r.data_out = {slave_addr, rd_mode};
          r.start_ctrl = STA_CLEAR;
        end
        ST_MT_SLA_ACK, ST_MT_DATA_ACK: begin
          // address ack always loads the first byte; data ack only while bytes remain
          if (code == ST_MT_SLA_ACK || tx_left != '0) begin
            r.load_data = 1'b1;
            r.data_out = tx_byte;
            r.tx_index = tx_pos[7:0];
            tx_pos = sat_inc(tx_pos);
            tx_left = sat_dec(tx_left);
          end else begin
            r.send_stop = 1'b1;
            r.done_res = 1'b1;
          end
          r.start_ctrl = STA_CLEAR;
        end
        ST_MT_SLA_NACK, ST_MT_DATA_NACK, ST_MR_SLA_NACK: begin
          r.send_stop = 1'b1;
          r.start_ctrl = STA_CLEAR;
          r.done_res = 1'b1;
        end
        ST_ARB_LOST: begin
          r.send_stop = 1'b1;
          r.done_res = 1'b1;
        end
        ST_MR_SLA_ACK: begin
          r.ack_mode = (rx_left <= 1) ? ACK_CLEAR : ACK_SET;
          r.start_ctrl = STA_CLEAR;
        end
        ST_MR_DATA_ACK, ST_MR_DATA_NACK: begin
          r.rx_valid = 1'b1;
          r.rx_data = bus_byte;
          r.rx_index = rx_pos[7:0];
          rx_pos = sat_inc(rx_pos);
          rx_left = sat_dec(rx_left);
          if (code == ST_MR_DATA_ACK) begin
            r.ack_mode = (rx_left <= 1) ? ACK_CLEAR : ACK_SET;
          end else begin
            r.send_stop = 1'b1;
            r.done_res = 1'b1;
          end
          r.start_ctrl = STA_CLEAR;
        end
        default: begin
          // unknown code: stop and retry the start
          r.send_stop = 1'b1;
          r.start_ctrl = STA_SET;
        end
      endcase
    end
    r.bytes_moved = rd_mode ? rx_pos : tx_pos;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      slave_addr = '0;
      len_send = '0;
      len_recv = '0;
      rd_mode = 1'b0;
      tx_left = '0;
      rx_left = '0;
      tx_pos = '0;
      rx_pos = '0;
      pending_actions.delete();
      open_results_o = 0;
    end else begin
      // Track register writes
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_SLAVE_ADDR: slave_addr = cfg_data_i[6:0];
          REG_SEND_LEN:   len_send = cfg_data_i;
          REG_RECV_LEN:   len_recv = cfg_data_i;
          default: ;
        endcase
      end

      // Compare a result beat against the oldest prediction
      if (m_tvalid_i && m_tready_i) begin
        results_seen_o++;
        if (pending_actions.size() == 0) begin
          $error("result beat arrived with no prediction pending");
          mismatches_o++;
        end else begin
          want = pending_actions.pop_front();
          check_field("load_data", 16'(want.load_data), 16'(m_tuser_i[0]));
          check_field("data_out", 16'(want.data_out), 16'(m_tdata_i[7:0]));
          check_field("tx_index", 16'(want.tx_index), 16'(m_tdata_i[15:8]));
          check_field("rx_valid", 16'(want.rx_valid), 16'(m_tuser_i[1]));
          check_field("rx_data", 16'(want.rx_data), 16'(m_tdata_i[23:16]));
          check_field("rx_index", 16'(want.rx_index), 16'(m_tdata_i[31:24]));
          check_field("ack_mode", 16'(want.ack_mode), 16'(m_tdata_i[33:32]));
          check_field("send_stop", 16'(want.send_stop), 16'(m_tdata_i[34]));
          check_field("start_ctrl", 16'(want.start_ctrl), 16'(m_tdata_i[36:35]));
          check_field("done_res", 16'(want.done_res), 16'(m_tlast_i));
          check_field("bytes_moved", 16'(want.bytes_moved), 16'(m_tdata_i[45:37]));
        end
      end

      // Predict each accepted input beat
      if (s_tvalid_i && s_tready_i) begin
        pending_actions.push_back(next_action(s_tuser_i, s_tdata_i[0], s_tdata_i[8:1],
                                              s_tdata_i[16:9], s_tdata_i[24:17]));
      end
      open_results_o = pending_actions.size();
    end
  end

endmodule

// File: bench/tb.sv
// Stimulus and verdict for the I2C master transfer sequencer bench.
`timescale 1ns / 1ps

module tb;
  import i2cmts_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int unsigned LONG_BURST = 513;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic [31:0]           s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tready = 1'b0;

  logic        cfg_ready_o;
  logic        s_tready_o;
  logic        m_tvalid_o;
  logic [47:0] m_tdata_o;
  logic [1:0]  m_tuser_o;
  logic        m_tlast_o;

  int mismatches;
  int open_results;
  int results_seen;

  int send_idle_pct = 16;
  int recv_idle_pct = 63;
  int items_sent = 0;
  int settings = 0;
  int send_len_now = 0;
  int recv_len_now = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  i2c_master_transfer_sequencer i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .s_tvalid_i  (s_tvalid),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata),
    .s_tuser_i   (s_tuser),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready),
    .m_tdata_o   (m_tdata_o),
    .m_tuser_o   (m_tuser_o),
    .m_tlast_o   (m_tlast_o)
  );

  i2cmts_check i_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .s_tvalid_i     (s_tvalid),
    .s_tready_i     (s_tready_o),
    .s_tdata_i      (s_tdata),
    .s_tuser_i      (s_tuser),
    .m_tvalid_i     (m_tvalid_o),
    .m_tready_i     (m_tready),
    .m_tdata_i      (m_tdata_o),
    .m_tuser_i      (m_tuser_o),
    .m_tlast_i      (m_tlast_o),
    .mismatches_o   (mismatches),
    .open_results_o (open_results),
    .results_seen_o (results_seen)
  );

  // Stall the result side at random
  always @(posedge clk_i) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Hard stop if the run hangs
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Drive one input beat, idling at random first
  task automatic put(input logic cmd, input logic rnw, input logic [7:0] code,
                     input logic [7:0] bus_byte, input logic [7:0] tx_byte);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {7'd0, tx_byte, bus_byte, code, rnw};
    do @(posedge clk_i); while (!s_tready_o);
    items_sent++;
  endtask

  // Status beat with random don't-care bits and random bytes
  task automatic status(input logic [7:0] code);
    put(CMD_STATUS, 1'($urandom), code | 8'($urandom_range(7)), 8'($urandom), 8'($urandom));
  endtask

  task automatic open_transfer(input logic rnw);
    put(CMD_START, rnw, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  function automatic logic [7:0] abort_code();
    case ($urandom_range(3))
      0: return ST_MT_DATA_NACK;
      1: return ST_ARB_LOST;
      2: return ST_RSTART;
      default: return 8'($urandom);
    endcase
  endfunction

  // Hold the sender until every predicted result has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    @(negedge clk_i);
    while (open_results != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic configure(input logic [8:0] addr, input logic [8:0] slen,
                           input logic [8:0] rlen);
    drain();
    write_reg(REG_SLAVE_ADDR, addr);
    write_reg(REG_SEND_LEN, slen);
    write_reg(REG_RECV_LEN, rlen);
    write_reg(REG_UNUSED, 9'($urandom));
    cfg_valid <= 1'b0;
    send_len_now = (slen > 256) ? 256 : int'(slen);
    recv_len_now = (rlen > 256) ? 256 : int'(rlen);
    settings++;
  endtask

  // Well-formed write transfer, sometimes cut short or overrun
  task automatic write_transfer();
    int beats;
    open_transfer(1'b0);
    status($urandom_range(1) ? ST_START : ST_RSTART);
    if ($urandom_range(9) == 0) begin
      status(ST_MT_SLA_NACK);
      return;
    end
    status(ST_MT_SLA_ACK);
    beats = (send_len_now > 1) ? send_len_now : 1;
    if ($urandom_range(7) == 0) beats++;
    for (int i = 0; i < beats; i++) begin
      if ($urandom_range(29) == 0) begin
        status(abort_code());
        return;
      end
      status(ST_MT_DATA_ACK);
    end
  endtask

  // Well-formed read transfer, sometimes cut short or overrun
  task automatic read_transfer();
    int beats;
    open_transfer(1'b1);
    status($urandom_range(1) ? ST_START : ST_RSTART);
    if ($urandom_range(9) == 0) begin
      status(ST_MR_SLA_NACK);
      return;
    end
    status(ST_MR_SLA_ACK);
    beats = (recv_len_now > 0) ? recv_len_now - 1 : 0;
    if ($urandom_range(7) == 0) beats++;
    for (int i = 0; i < beats; i++) begin
      if ($urandom_range(29) == 0) begin
        status(abort_code());
        return;
      end
      status(ST_MR_DATA_ACK);
    end
    status(ST_MR_DATA_NACK);
  endtask

  // Mostly whole transfers, with loose beats mixed in
  task automatic random_traffic(input int n);
    int goal;
    goal = items_sent + n;
    while (items_sent < goal) begin
      case ($urandom_range(9))
        0, 1, 2, 3: write_transfer();
        4, 5, 6:    read_transfer();
        default:    put(1'($urandom), 1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      endcase
    end
  endtask

  initial begin
    int directed;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset state, every status code, counter edges
    put(CMD_STATUS, 1'b1, ST_START | 8'h07, 8'hFF, 8'hFF);
    configure(9'h1FF, 9'd1, 9'd2);
    put(CMD_START, 1'b0, 8'hFF, 8'hFF, 8'hFF);
    put(CMD_STATUS, 1'b0, ST_RSTART, 8'h00, 8'h00);
    put(CMD_STATUS, 1'b1, ST_MT_SLA_ACK, 8'h00, 8'hFF);
    put(CMD_STATUS, 1'b0, ST_MT_DATA_ACK, 8'hFF, 8'h00);
    status(ST_MT_SLA_NACK);
    status(ST_MT_DATA_NACK);
    status(ST_MR_SLA_NACK);
    status(ST_ARB_LOST);
    put(CMD_STATUS, 1'b0, 8'h00, 8'h00, 8'h00);
    put(CMD_STATUS, 1'b1, 8'hFF, 8'hFF, 8'hFF);
    put(CMD_START, 1'b1, 8'h00, 8'h00, 8'h00);
    status(ST_START);
    status(ST_MR_SLA_ACK);
    put(CMD_STATUS, 1'b0, ST_MR_DATA_ACK, 8'hFF, 8'h00);
    put(CMD_STATUS, 1'b1, ST_MR_DATA_ACK, 8'h00, 8'hFF);
    put(CMD_STATUS, 1'b0, ST_MR_DATA_NACK, 8'hA5, 8'h5A);
    status(ST_MR_SLA_ACK);
    configure(9'h000, 9'd0, 9'd0);
    open_transfer(1'b0);
    status(ST_MT_SLA_ACK);
    status(ST_MT_DATA_ACK);
    directed = items_sent;

    // Sender idles lightly, receiver heavily
    configure(9'($urandom), 9'd3, 9'd4);
    random_traffic(40);
    configure(9'h000, 9'd0, 9'd0);
    random_traffic(20);

    // Sender idles heavily, receiver lightly
    send_idle_pct = 63;
    recv_idle_pct = 16;
    configure(9'h055, 9'd9, 9'd1);
    random_traffic(40);
    configure(9'h12A, 9'd2, 9'd6);
    random_traffic(20);

    // No idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (2) begin
      configure(9'($urandom), 9'($urandom_range(1, 8)), 9'($urandom_range(1, 8)));
      random_traffic(20);
    end

    // Long burst: clamp the send length and drive the send position into saturation
    configure(9'h07F, 9'd511, 9'd3);
    open_transfer(1'b0);
    status(ST_START);
    repeat (LONG_BURST) status(ST_MT_SLA_ACK);
    status(ST_MT_DATA_ACK);
    open_transfer(1'b1);
    status(ST_START);
    status(ST_MR_SLA_ACK);
    repeat (2) status(ST_MR_DATA_ACK);
    status(ST_MR_DATA_NACK);

    drain();
    repeat (8) @(posedge clk_i);

    $display("Drove %0d beats (%0d directed) under %0d register settings;", items_sent,
             directed, settings);
    $display("checked %0d result beats including length clamping and send position saturation.",
             results_seen);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
